@@ hdl/point_projection_depth_buffer_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the point projection depth buffer
// Short forms for the concurrent checks used in the design files.
// ----------------------------------------------------------------------------
`ifndef POINT_PROJECTION_DEPTH_BUFFER_MACROS_SVH
`define POINT_PROJECTION_DEPTH_BUFFER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PPDB_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PPDB_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/ppdb_pkg.sv @@
// ----------------------------------------------------------------------------
// Point projection depth buffer package
// Shared widths, reset values, register indexes and the lane status type.
// ----------------------------------------------------------------------------
package ppdb_pkg;

    // Default image size.
    localparam int IMAGE_WIDTH_DEF  = 640;
    localparam int IMAGE_HEIGHT_DEF = 480;

    // Field widths.
    localparam int COORD_W    = 32;
    localparam int FOCAL_W    = 24;
    localparam int CENTER_W   = 20;
    localparam int DEPTH_W    = 31;
    localparam int COL_OUT_W  = 10;
    localparam int ROW_OUT_W  = 9;

    // Focal and centre values carry 8 fraction bits.
    localparam int FRAC_SHIFT = 8;

    // Numerator coord*focal + center*depth, its magnitude, and the divisor depth*256.
    localparam int NUM_W = COORD_W + FOCAL_W + 1;
    localparam int MAG_W = NUM_W - 1;
    localparam int DEN_W = DEPTH_W + FRAC_SHIFT;

    // Cloud tag stored with each depth entry.
    localparam int EPOCH_W = 8;

    // Configuration port.
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [FOCAL_W-1:0]  FOCAL_X_RST  = 24'd128000;
    localparam logic [FOCAL_W-1:0]  FOCAL_Y_RST  = 24'd128000;
    localparam logic [CENTER_W-1:0] CENTER_X_RST = 20'd81920;
    localparam logic [CENTER_W-1:0] CENTER_Y_RST = 20'd61440;

    typedef enum logic [1:0] {
        REG_FOCAL_X  = 2'd0,
        REG_FOCAL_Y  = 2'd1,
        REG_CENTER_X = 2'd2,
        REG_CENTER_Y = 2'd3
    } t_reg_idx;

    // Status a projection lane reports when it finishes.
    typedef struct packed {
        logic done;
        logic in_range;
    } t_lane_status;

endpackage

@@ hdl/ppdb_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ppdb_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hdl/ppdb_lane.sv @@
// ----------------------------------------------------------------------------
// Projection lane
// Computes trunc((coord*focal + center*depth) / (256*depth)) with a bit-serial
// shift-add multiplier and a restoring divider, and checks it against a limit.
// ----------------------------------------------------------------------------
module ppdb_lane #(
    parameter int LIMIT  = 640,
    parameter int QUOT_W = 10
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_start,
    input  logic signed [ppdb_pkg::COORD_W-1:0]  i_coord,
    input  logic [ppdb_pkg::FOCAL_W-1:0]         i_focal,
    input  logic [ppdb_pkg::CENTER_W-1:0]        i_center,
    input  logic [ppdb_pkg::DEPTH_W-1:0]         i_depth,
    output ppdb_pkg::t_lane_status               o_status,
    output logic [QUOT_W-1:0]                    o_quot
);
    import ppdb_pkg::*;

    localparam int CNT_W = $clog2(FOCAL_W + 1);
    localparam logic [QUOT_W:0] LIMIT_V = (QUOT_W + 1)'(LIMIT);

    typedef enum logic [2:0] {
        L_IDLE,
        L_MUL,
        L_ABS,
        L_CHK,
        L_DIV,
        L_DONE
    } t_lstate;

    t_lstate            r_state;
    logic [CNT_W-1:0]   r_cnt;
    logic [NUM_W-1:0]   r_acc;
    logic [NUM_W-1:0]   r_mc_a;
    logic [NUM_W-1:0]   r_mc_b;
    logic [FOCAL_W-1:0] r_mp_a;
    logic [FOCAL_W-1:0] r_mp_b;
    logic               r_neg;
    logic               r_ovf;
    logic [MAG_W-1:0]   r_mag;
    logic [DEN_W-1:0]   r_den;
    logic [DEN_W-1:0]   r_rem;
    logic [QUOT_W-1:0]  r_low;
    logic [QUOT_W-1:0]  r_quot;
    t_lane_status       r_status;

    logic [NUM_W-1:0] w_pp_a;
    logic [NUM_W-1:0] w_pp_b;
    logic [NUM_W-1:0] n_acc;
    logic [NUM_W-1:0] w_neg_acc;
    logic [MAG_W-1:0] n_mag;
    logic [MAG_W-1:0] w_hi;
    logic             w_ovf;
    logic [DEN_W:0]   w_trial;
    logic [DEN_W:0]   w_diff;
    logic             w_fits;
    logic [DEN_W-1:0] n_rem;

    // Datapath: one multiplier bit, or one quotient bit, per cycle.
    always_comb begin
        w_pp_a    = r_mp_a[0] ? r_mc_a : '0;
        w_pp_b    = r_mp_b[0] ? r_mc_b : '0;
        n_acc     = r_acc + w_pp_a + w_pp_b;
        w_neg_acc = '0 - r_acc;
        n_mag     = r_acc[NUM_W-1] ? w_neg_acc[MAG_W-1:0] : r_acc[MAG_W-1:0];
        w_hi      = r_mag >> QUOT_W;
        w_ovf     = (w_hi >= MAG_W'(r_den));
        w_trial   = {r_rem, r_low[QUOT_W-1]};
        w_fits    = (w_trial >= {1'b0, r_den});
        w_diff    = w_trial - {1'b0, r_den};
        n_rem     = w_fits ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
    end

    // Sequencer with its registered status.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= L_IDLE;
            r_status <= '0;
        end else begin
            r_status.done <= (r_state == L_DONE);
            case (r_state)
                L_IDLE: begin
                    if (i_start) begin
                        r_acc   <= '0;
                        r_mc_a  <= {{(NUM_W - COORD_W){i_coord[COORD_W-1]}}, i_coord};
                        r_mc_b  <= NUM_W'(i_depth);
                        r_mp_a  <= i_focal;
                        r_mp_b  <= FOCAL_W'(i_center);
                        r_den   <= {i_depth, {FRAC_SHIFT{1'b0}}};
                        r_cnt   <= '0;
                        r_state <= L_MUL;
                    end
                end
                L_MUL: begin
                    r_acc  <= n_acc;
                    r_mc_a <= r_mc_a << 1;
                    r_mc_b <= r_mc_b << 1;
                    r_mp_a <= r_mp_a >> 1;
                    r_mp_b <= r_mp_b >> 1;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(FOCAL_W - 1)) begin
                        r_state <= L_ABS;
                    end
                end
                L_ABS: begin
                    r_neg   <= r_acc[NUM_W-1];
                    r_mag   <= n_mag;
                    r_state <= L_CHK;
                end
                L_CHK: begin
                    // A quotient too large for the divider is out of the image. The
                    // divide still runs so that both lanes keep the same schedule.
                    r_ovf   <= w_ovf;
                    r_rem   <= w_hi[DEN_W-1:0];
                    r_low   <= r_mag[QUOT_W-1:0];
                    r_quot  <= '0;
                    r_cnt   <= '0;
                    r_state <= L_DIV;
                end
                L_DIV: begin
                    r_rem  <= n_rem;
                    r_quot <= QUOT_W'({r_quot, w_fits});
                    r_low  <= r_low << 1;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(QUOT_W - 1)) begin
                        r_state <= L_DONE;
                    end
                end
                L_DONE: begin
                    // A negative value truncates toward zero, so only zero survives.
                    r_status.in_range <= !r_ovf && (r_neg ? (r_quot == '0)
                                                          : ({1'b0, r_quot} < LIMIT_V));
                    r_state           <= L_IDLE;
                end
                default: begin
                    r_state <= L_IDLE;
                end
            endcase
        end
    end

    assign o_status = r_status;
    assign o_quot   = r_quot;

endmodule

@@ hdl/point_projection_depth_buffer.sv @@
// ----------------------------------------------------------------------------
// Point projection depth buffer
// Projects camera-frame points through a pinhole model and keeps, per pixel,
// only points nearer than anything seen earlier in the same cloud.
//
// Usage: points enter on the input channel (i_in_valid / o_in_stall), one
// transaction per point; kept points leave on the output channel
// (o_out_valid / i_out_stall) with their pixel. Dropped points give nothing.
// The block takes no new point until it is through with the last: a kept point
// passes the lane calculation, a 24-step serial multiply and a restoring
// divide with one quotient bit per cycle, and then the states S_READ, S_CMP
// and S_WRITE. A point with non-positive depth is dropped at once, and one
// outside the image is dropped after the lane calculation, skipping the rest.
// After reset a clearing pass writes every pixel of the depth memory, one per
// cycle, with the input stalled; the same pass runs once every 256 new clouds
// when the cloud tag wraps. Otherwise a new cloud costs nothing. A stalled
// result waits in the output register while the next point is computed; that
// point then waits for the register.
// Configuration goes through the APB port while the block is idle.
// ----------------------------------------------------------------------------
`include "point_projection_depth_buffer_macros.svh"

module point_projection_depth_buffer #(
    parameter int IMAGE_WIDTH  = ppdb_pkg::IMAGE_WIDTH_DEF,
    parameter int IMAGE_HEIGHT = ppdb_pkg::IMAGE_HEIGHT_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ppdb_pkg::CFG_ADDR_W-1:0]       paddr,
    input  logic [ppdb_pkg::CFG_DATA_W-1:0]       pwdata,
    output logic [ppdb_pkg::CFG_DATA_W-1:0]       prdata,
    output logic                                  pready,
    // Point input
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic                                  i_new_cloud,
    input  logic signed [ppdb_pkg::COORD_W-1:0]   i_point_x,
    input  logic signed [ppdb_pkg::COORD_W-1:0]   i_point_y,
    input  logic signed [ppdb_pkg::COORD_W-1:0]   i_point_z,
    // Kept point output
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [ppdb_pkg::COL_OUT_W-1:0]        o_pixel_column,
    output logic [ppdb_pkg::ROW_OUT_W-1:0]        o_pixel_row,
    output logic signed [ppdb_pkg::COORD_W-1:0]   o_kept_x,
    output logic signed [ppdb_pkg::COORD_W-1:0]   o_kept_y,
    output logic [ppdb_pkg::DEPTH_W-1:0]          o_kept_z
);
    import ppdb_pkg::*;

    localparam int DEPTH   = IMAGE_WIDTH * IMAGE_HEIGHT;
    localparam int ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int MAX_DIM = (IMAGE_WIDTH > IMAGE_HEIGHT) ? IMAGE_WIDTH : IMAGE_HEIGHT;
    localparam int QUOT_W  = $clog2(MAX_DIM + 1);
    localparam int RAM_W   = EPOCH_W + DEPTH_W;
    localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_CALC,
        S_READ,
        S_CMP,
        S_WRITE
    } t_state;

    // Configuration registers
    logic [FOCAL_W-1:0]  r_focal_x;
    logic [FOCAL_W-1:0]  r_focal_y;
    logic [CENTER_W-1:0] r_center_x;
    logic [CENTER_W-1:0] r_center_y;

    // Control and point registers
    t_state                     r_state;
    logic [EPOCH_W-1:0]         r_epoch;
    logic [ADDR_W-1:0]          r_clr_addr;
    logic                       r_has_point;
    logic                       r_z_pos;
    logic                       r_lane_start;
    logic signed [COORD_W-1:0]  r_x;
    logic signed [COORD_W-1:0]  r_y;
    logic [DEPTH_W-1:0]         r_z;
    logic [ADDR_W-1:0]          r_addr;

    // Output register
    logic                       r_out_valid;
    logic [COL_OUT_W-1:0]       r_out_col;
    logic [ROW_OUT_W-1:0]       r_out_row;
    logic signed [COORD_W-1:0]  r_out_x;
    logic signed [COORD_W-1:0]  r_out_y;
    logic [DEPTH_W-1:0]         r_out_z;

    t_reg_idx           w_reg_idx;
    logic               w_cfg_wr;
    logic               w_in_accept;
    logic               w_out_free;
    logic               w_in_pos;
    logic               w_lane_go;
    t_lane_status       w_col_st;
    t_lane_status       w_row_st;
    logic [QUOT_W-1:0]  w_col_q;
    logic [QUOT_W-1:0]  w_row_q;
    logic [ADDR_W-1:0]  w_addr;
    logic               w_ram_we;
    logic [ADDR_W-1:0]  w_ram_waddr;
    logic [RAM_W-1:0]   w_ram_wdata;
    logic [RAM_W-1:0]   w_ram_rdata;
    logic [EPOCH_W-1:0] w_rd_tag;
    logic [DEPTH_W-1:0] w_rd_depth;
    logic               w_keep;

    // Configuration port: writes complete in the access phase, reads are plain muxing.
    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[CFG_ADDR_W-1:2]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal_x  <= FOCAL_X_RST;
            r_focal_y  <= FOCAL_Y_RST;
            r_center_x <= CENTER_X_RST;
            r_center_y <= CENTER_Y_RST;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_FOCAL_X:  r_focal_x  <= pwdata[FOCAL_W-1:0];
                REG_FOCAL_Y:  r_focal_y  <= pwdata[FOCAL_W-1:0];
                REG_CENTER_X: r_center_x <= pwdata[CENTER_W-1:0];
                REG_CENTER_Y: r_center_y <= pwdata[CENTER_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_reg_idx)
            REG_FOCAL_X:  prdata = CFG_DATA_W'(r_focal_x);
            REG_FOCAL_Y:  prdata = CFG_DATA_W'(r_focal_y);
            REG_CENTER_X: prdata = CFG_DATA_W'(r_center_x);
            REG_CENTER_Y: prdata = CFG_DATA_W'(r_center_y);
            default:      prdata = '0;
        endcase
    end

    // Handshake helpers.
    assign o_in_stall  = (r_state != S_IDLE);
    assign w_in_accept = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_in_pos    = !i_point_z[COORD_W-1] && (i_point_z != '0);

    // The lanes start on a new point with positive depth, or after a wrap wipe.
    assign w_lane_go = (w_in_accept && w_in_pos && !(i_new_cloud && (r_epoch == EPOCH_MAX)))
                    || ((r_state == S_CLEAR) && (r_clr_addr == ADDR_W'(DEPTH - 1))
                        && r_has_point && r_z_pos);

    // Column and row lanes run side by side on the same schedule.
    ppdb_lane #(
        .LIMIT  (IMAGE_WIDTH),
        .QUOT_W (QUOT_W)
    ) u_lane_col (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_lane_start),
        .i_coord  (r_x),
        .i_focal  (r_focal_x),
        .i_center (r_center_x),
        .i_depth  (r_z),
        .o_status (w_col_st),
        .o_quot   (w_col_q)
    );

    ppdb_lane #(
        .LIMIT  (IMAGE_HEIGHT),
        .QUOT_W (QUOT_W)
    ) u_lane_row (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_lane_start),
        .i_coord  (r_y),
        .i_focal  (r_focal_y),
        .i_center (r_center_y),
        .i_depth  (r_z),
        .o_status (w_row_st),
        .o_quot   (w_row_q)
    );

    // Pixel address, row major.
    assign w_addr = ADDR_W'(w_row_q) * ADDR_W'(IMAGE_WIDTH) + ADDR_W'(w_col_q);

    // Depth memory: each entry holds the cloud tag and the nearest depth.
    // An entry whose tag differs from the current cloud reads as empty.
    assign w_ram_we    = (r_state == S_CLEAR) || ((r_state == S_WRITE) && w_out_free);
    assign w_ram_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_addr;
    assign w_ram_wdata = (r_state == S_CLEAR) ? '0 : {r_epoch, r_z};

    ppdb_ram #(
        .WIDTH  (RAM_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_depth_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (w_ram_waddr),
        .i_wr_data (w_ram_wdata),
        .i_rd_addr (r_addr),
        .o_rd_data (w_ram_rdata)
    );

    assign w_rd_tag   = w_ram_rdata[RAM_W-1:DEPTH_W];
    assign w_rd_depth = w_ram_rdata[DEPTH_W-1:0];
    assign w_keep     = (w_rd_tag != r_epoch) || (w_rd_depth == '0) || (r_z < w_rd_depth);

    // Main sequencer with the output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_epoch      <= '0;
            r_clr_addr   <= '0;
            r_has_point  <= 1'b0;
            r_lane_start <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_lane_start <= w_lane_go;

            // Output register: a taken result frees the slot.
            if ((r_state == S_WRITE) && w_out_free) begin
                r_out_valid <= 1'b1;
                r_out_col   <= COL_OUT_W'(w_col_q);
                r_out_row   <= ROW_OUT_W'(w_row_q);
                r_out_x     <= r_x;
                r_out_y     <= r_y;
                r_out_z     <= r_z;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                        r_has_point <= 1'b0;
                        if (r_has_point && r_z_pos) begin
                            r_state <= S_CALC;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else begin
                        r_clr_addr <= r_clr_addr + 1'b1;
                    end
                end
                S_IDLE: begin
                    if (w_in_accept) begin
                        r_x     <= i_point_x;
                        r_y     <= i_point_y;
                        r_z     <= i_point_z[DEPTH_W-1:0];
                        r_z_pos <= w_in_pos;
                        if (i_new_cloud && (r_epoch == EPOCH_MAX)) begin
                            // Tag space used up: wipe the memory before this point.
                            r_epoch     <= '0;
                            r_clr_addr  <= '0;
                            r_has_point <= 1'b1;
                            r_state     <= S_CLEAR;
                        end else begin
                            if (i_new_cloud) begin
                                r_epoch <= r_epoch + 1'b1;
                            end
                            if (w_in_pos) begin
                                r_state <= S_CALC;
                            end
                        end
                    end
                end
                S_CALC: begin
                    if (w_col_st.done) begin
                        if (w_col_st.in_range && w_row_st.in_range) begin
                            r_addr  <= w_addr;
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_state <= w_keep ? S_WRITE : S_IDLE;
                end
                S_WRITE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_pixel_column = r_out_col;
    assign o_pixel_row    = r_out_row;
    assign o_kept_x       = r_out_x;
    assign o_kept_y       = r_out_y;
    assign o_kept_z       = r_out_z;

    // Checks on the sequencing.
    `PPDB_ASSERT_SAME(a_lanes_in_step, i_clk, i_rst_n, w_col_st.done, w_row_st.done, "lanes finished apart")
    `PPDB_ASSERT_NEXT(a_epoch_steady, i_clk, i_rst_n, !w_in_accept, $stable(r_epoch), "cloud tag moved without a point")
    `PPDB_ASSERT_NEXT(a_write_gives_result, i_clk, i_rst_n, (r_state == S_WRITE) && w_out_free, o_out_valid, "depth written without a result")
    `PPDB_ASSERT_SAME(a_kept_depth_nonzero, i_clk, i_rst_n, w_ram_we && (r_state != S_CLEAR), r_z != '0, "zero depth stored")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Point projection depth buffer testbench
// Drives camera-frame points with random pacing on both channels, predicts
// each kept point with an exact integer pinhole projection and a per-pixel
// nearest-depth map, and checks every output transaction field by field.
// The camera registers are rewritten between phases, extremes included.
// ----------------------------------------------------------------------------
module tb_top;
    import ppdb_pkg::*;

    localparam int     IMG_W           = IMAGE_WIDTH_DEF;
    localparam int     IMG_H           = IMAGE_HEIGHT_DEF;
    localparam int     PHASES          = 8;
    localparam int     ITEMS_PER_PHASE = 230;
    localparam int     SETTLE_CYCLES   = 60;
    localparam int     LIMIT           = 3_000_000;
    localparam longint COORD_MAX       = 64'sd2147483647;
    localparam longint COORD_MIN       = -64'sd2147483648;

    // One kept point as it leaves the block.
    typedef struct {
        logic [COL_OUT_W-1:0]       col;
        logic [ROW_OUT_W-1:0]       row;
        logic signed [COORD_W-1:0]  x;
        logic signed [COORD_W-1:0]  y;
        logic [DEPTH_W-1:0]         z;
    } t_kept_point;

    // Predicts kept points and holds them until the block delivers them.
    class t_depth_scoreboard;
        bit [FOCAL_W-1:0]  fx;
        bit [FOCAL_W-1:0]  fy;
        bit [CENTER_W-1:0] cx;
        bit [CENTER_W-1:0] cy;
        longint            nearest_depth[int];
        t_kept_point       kept_q[$];
        int                errors;

        function new();
            fx     = FOCAL_X_RST;
            fy     = FOCAL_Y_RST;
            cx     = CENTER_X_RST;
            cy     = CENTER_Y_RST;
            errors = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_FOCAL_X:  fx = value[FOCAL_W-1:0];
                REG_FOCAL_Y:  fy = value[FOCAL_W-1:0];
                REG_CENTER_X: cx = value[CENTER_W-1:0];
                REG_CENTER_Y: cy = value[CENTER_W-1:0];
                default: ;
            endcase
        endfunction

        // Exact pixel index: (c*f + ctr*z) / (256*z), truncated toward zero.
        function longint pixel_of(longint c, longint f, longint ctr, longint z);
            return (c * f + ctr * z) / (z * 256);
        endfunction

        function void note_point(bit new_cloud, logic signed [COORD_W-1:0] x,
                                 logic signed [COORD_W-1:0] y,
                                 logic signed [COORD_W-1:0] z);
            longint      col;
            longint      row;
            int          key;
            t_kept_point e;
            if (new_cloud)
                nearest_depth.delete();
            if (z <= 0)
                return;
            col = pixel_of(x, fx, cx, z);
            row = pixel_of(y, fy, cy, z);
            if (col < 0 || col >= IMG_W || row < 0 || row >= IMG_H)
                return;
            key = int'(row) * IMG_W + int'(col);
            if (nearest_depth.exists(key) && longint'(z) >= nearest_depth[key])
                return;
            nearest_depth[key] = z;
            e.col = col[COL_OUT_W-1:0];
            e.row = row[ROW_OUT_W-1:0];
            e.x   = x;
            e.y   = y;
            e.z   = z[DEPTH_W-1:0];
            kept_q.insert(kept_q.size(), e);
        endfunction

        function void compare(string field, longint want, longint got);
            if (want != got) begin
                $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_kept_point got);
            t_kept_point e;
            if (kept_q.size() == 0) begin
                $display("%0t ns: unexpected point at pixel (%0d, %0d), z %0d",
                         $time, got.col, got.row, got.z);
                errors++;
                return;
            end
            e = kept_q.pop_front();
            compare("pixel_column", e.col, got.col);
            compare("pixel_row", e.row, got.row);
            compare("kept_x", e.x, got.x);
            compare("kept_y", e.y, got.y);
            compare("kept_z", e.z, got.z);
        endfunction

        function int pending();
            return kept_q.size();
        endfunction
    endclass

    logic                        i_clk          = 1'b0;
    logic                        i_rst_n        = 1'b0;
    logic                        psel           = 1'b0;
    logic                        penable        = 1'b0;
    logic                        pwrite         = 1'b0;
    logic [CFG_ADDR_W-1:0]       paddr          = '0;
    logic [CFG_DATA_W-1:0]       pwdata         = '0;
    logic [CFG_DATA_W-1:0]       prdata;
    logic                        pready;
    logic                        i_in_valid     = 1'b0;
    logic                        o_in_stall;
    logic                        i_new_cloud    = 1'b0;
    logic signed [COORD_W-1:0]   i_point_x      = '0;
    logic signed [COORD_W-1:0]   i_point_y      = '0;
    logic signed [COORD_W-1:0]   i_point_z      = '0;
    logic                        o_out_valid;
    logic                        i_out_stall    = 1'b0;
    logic [COL_OUT_W-1:0]        o_pixel_column;
    logic [ROW_OUT_W-1:0]        o_pixel_row;
    logic signed [COORD_W-1:0]   o_kept_x;
    logic signed [COORD_W-1:0]   o_kept_y;
    logic [DEPTH_W-1:0]          o_kept_z;

    t_depth_scoreboard sb = new();

    // Pacing state shared by both sides; calm stretches carry no idling.
    bit          calm          = 1'b0;
    int          points_sent   = 0;
    int          hold_left     = 0;
    int          cycle_count   = 0;
    t_kept_point seen_point;

    // Recently aimed pixels, reused to provoke depth comparisons.
    int          recent_u[$];
    int          recent_v[$];
    longint      recent_z[$];

    point_projection_depth_buffer DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_new_cloud    (i_new_cloud),
        .i_point_x      (i_point_x),
        .i_point_y      (i_point_y),
        .i_point_z      (i_point_z),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pixel_column (o_pixel_column),
        .o_pixel_row    (o_pixel_row),
        .o_kept_x       (o_kept_x),
        .o_kept_y       (o_kept_y),
        .o_kept_z       (o_kept_z)
    );

    // Clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int draw_wait();
        return calm ? 0 : int'($urandom_range(0, 19));
    endfunction

    // Coordinate that projects to about target pixel plus frac/256.
    function automatic logic signed [COORD_W-1:0] coord_for(int target, int frac,
                                                            longint f, longint ctr,
                                                            longint z);
        longint c;
        if (f == 0)
            return $urandom;
        c = ((longint'(target) * 256 + frac - ctr) * z) / f;
        if (c > COORD_MAX)
            c = COORD_MAX;
        if (c < COORD_MIN)
            c = COORD_MIN;
        return c[COORD_W-1:0];
    endfunction

    function automatic longint draw_depth();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(1, 16);
            1:       return $urandom_range(32'h0100_0000, 32'h7fff_ffff);
            default: return $urandom_range(256, 100 << 10);
        endcase
    endfunction

    // Output side: check each accepted transaction, then stall at random.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                seen_point.col = o_pixel_column;
                seen_point.row = o_pixel_row;
                seen_point.x   = o_kept_x;
                seen_point.y   = o_kept_y;
                seen_point.z   = o_kept_z;
                sb.check_result(seen_point);
                hold_left = draw_wait();
            end else if (hold_left > 0) begin
                hold_left--;
            end
        end
        i_out_stall <= (hold_left != 0);
    end

    // Presents one point and waits until the block takes it.
    task automatic send_point(bit new_cloud, logic signed [COORD_W-1:0] x,
                              logic signed [COORD_W-1:0] y,
                              logic signed [COORD_W-1:0] z);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_new_cloud <= new_cloud;
        i_point_x   <= x;
        i_point_y   <= y;
        i_point_z   <= z;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_point(new_cloud, x, y, z);
        points_sent++;
        if (points_sent % 64 == 0)
            calm = ($urandom_range(0, 3) == 0);
    endtask

    // Aims a point at pixel (u, v) under the current camera registers.
    task automatic send_aimed(bit new_cloud, int u, int v, int frac, longint z);
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        x = coord_for(u, frac, sb.fx, sb.cx, z);
        y = coord_for(v, frac, sb.fy, sb.cy, z);
        recent_u.insert(recent_u.size(), u);
        recent_v.insert(recent_v.size(), v);
        recent_z.insert(recent_z.size(), z);
        if (recent_u.size() > 16) begin
            void'(recent_u.pop_front());
            void'(recent_v.pop_front());
            void'(recent_z.pop_front());
        end
        send_point(new_cloud, x, y, z[COORD_W-1:0]);
    endtask

    // Drops valid and lets the block drain completely.
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: setup cycle, then access cycle.
    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_reg(idx, value);
    endtask

    // Register settings per phase: two sets of extremes, then random cameras.
    task automatic configure(int phase);
        if (phase == 1) begin
            write_reg(REG_FOCAL_X, 0);
            write_reg(REG_FOCAL_Y, CFG_DATA_W'(24'hff_ffff));
            write_reg(REG_CENTER_X, 0);
            write_reg(REG_CENTER_Y, CFG_DATA_W'(20'hf_ffff));
        end else if (phase == 2) begin
            write_reg(REG_FOCAL_X, CFG_DATA_W'(24'hff_ffff));
            write_reg(REG_FOCAL_Y, 0);
            write_reg(REG_CENTER_X, CFG_DATA_W'(20'hf_ffff));
            write_reg(REG_CENTER_Y, 0);
        end else begin
            write_reg(REG_FOCAL_X, $urandom_range(100 * 256, 1500 * 256));
            write_reg(REG_FOCAL_Y, $urandom_range(100 * 256, 1500 * 256));
            write_reg(REG_CENTER_X, $urandom_range(0, IMG_W * 256));
            write_reg(REG_CENTER_Y, $urandom_range(0, IMG_H * 256));
        end
    endtask

    // One random point: mostly aimed into or near the image, some noise.
    task automatic send_random();
        int     kind;
        int     pick;
        bit     nc;
        longint z;
        kind = $urandom_range(0, 99);
        nc   = ($urandom_range(0, 15) == 0);
        if (kind < 10) begin
            send_point(nc, $urandom, $urandom, $urandom);
        end else if (kind < 20) begin
            case ($urandom_range(0, 3))
                0:       z = 0;
                1:       z = -1;
                2:       z = COORD_MIN;
                default: z = -longint'($urandom_range(1, 32'h7fff_ffff));
            endcase
            send_point(nc, $urandom, $urandom, z[COORD_W-1:0]);
        end else if (kind < 55 && recent_u.size() > 0) begin
            pick = $urandom_range(0, recent_u.size() - 1);
            z    = recent_z[pick] + int'($urandom_range(0, 6)) - 3;
            send_aimed(nc, recent_u[pick], recent_v[pick], $urandom_range(0, 255), z);
        end else if ($urandom_range(0, 9) == 0) begin
            send_aimed(nc, int'($urandom_range(0, IMG_W + 60)) - 30,
                       int'($urandom_range(0, IMG_H + 60)) - 30,
                       $urandom_range(0, 255), draw_depth());
        end else begin
            send_aimed(nc, $urandom_range(0, IMG_W - 1), $urandom_range(0, IMG_H - 1),
                       $urandom_range(0, 255), draw_depth());
        end
    endtask

    // Main sequence: reset, directed points, then random phases.
    initial begin : stimulus
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed points under the reset camera (500 px focal, centre 320, 240).
        send_point(1'b1, 0, 0, 1024);
        send_point(1'b0, 0, 0, 1024);
        send_point(1'b0, 0, 0, 2048);
        send_point(1'b0, 0, 0, 1023);
        send_point(1'b0, 0, 0, 1);
        send_point(1'b0, 1000, 1000, 0);
        send_point(1'b0, 0, 0, -1);
        send_point(1'b0, COORD_W'(COORD_MAX), COORD_W'(COORD_MIN), COORD_W'(COORD_MIN));
        send_point(1'b0, COORD_W'(COORD_MAX), COORD_W'(COORD_MIN), COORD_W'(COORD_MAX));
        send_point(1'b0, COORD_W'(COORD_MIN), COORD_W'(COORD_MAX), 1);
        send_point(1'b0, 0, COORD_W'(COORD_MIN), COORD_W'(COORD_MAX));
        send_aimed(1'b0, 0, 0, 128, 1024);
        send_aimed(1'b0, IMG_W - 1, IMG_H - 1, 128, 1024);
        send_aimed(1'b0, IMG_W, 0, 128, 1024);
        send_aimed(1'b0, 0, IMG_H, 128, 1024);
        send_aimed(1'b0, -1, 100, 128, 1024);
        send_aimed(1'b0, -2, 5, 128, 1024);
        send_aimed(1'b0, 320, IMG_H - 1, 128, COORD_MAX);
        send_point(1'b1, 0, 0, 4096);
        send_point(1'b0, 0, 0, 4096);

        for (int phase = 1; phase <= PHASES; phase++) begin
            settle();
            configure(phase);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_random();
        end
        settle();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin : watchdog
        while (cycle_count < LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

endmodule
